// ----- hw/rtl/tfn_pkg.sv -----
// types and widths shared by the triangle face normal pipeline
package tfn_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned EDGE_W  = 17;
    localparam int unsigned PROD_W  = 34;
    localparam int unsigned CROSS_W = 35;
    localparam int unsigned MAG_W   = 33;
    localparam int unsigned MSQ_W   = 66;
    localparam int unsigned SUM_W   = 68;
    localparam int unsigned REM_W   = 94;
    localparam int unsigned ACC_W   = 83;
    localparam int unsigned CMP_W   = 99;
    localparam int unsigned Q_W     = 15;
    localparam int unsigned LANES   = 3;

    typedef struct packed {
        logic signed [COORD_W-1:0] v0_x;
        logic signed [COORD_W-1:0] v0_y;
        logic signed [COORD_W-1:0] v0_z;
        logic signed [COORD_W-1:0] v1_x;
        logic signed [COORD_W-1:0] v1_y;
        logic signed [COORD_W-1:0] v1_z;
        logic signed [COORD_W-1:0] v2_x;
        logic signed [COORD_W-1:0] v2_y;
        logic signed [COORD_W-1:0] v2_z;
        logic                      last_triangle;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] normal_x;
        logic signed [COORD_W-1:0] normal_y;
        logic signed [COORD_W-1:0] normal_z;
        logic                      degenerate;
        logic                      last_out;
    } t_out_item;

    // magnitudes of the cross product, lane 0 is x
    typedef struct packed {
        logic [LANES-1:0][MAG_W-1:0] m;
        logic [LANES-1:0]            neg;
        logic                        degen;
        logic                        last;
    } t_mag;

    // state of the bit-serial normalizer for one item
    typedef struct packed {
        logic [LANES-1:0][REM_W-1:0] r;
        logic [LANES-1:0][ACC_W-1:0] b;
        logic [LANES-1:0][Q_W-1:0]   q;
        logic [SUM_W-1:0]            s;
        logic [LANES-1:0]            neg;
        logic                        degen;
        logic                        last;
    } t_norm;

endpackage

// ----- hw/rtl/triangle_face_normal_unit.sv -----
// Flat face normal of a triangle: takes three Q8.8 vertices per transfer and returns the
// unit normal of (v1-v0) x (v2-v0) in Q1.14, truncated toward zero, with a degenerate
// flag for a zero cross product (normal then zero) and the last-triangle flag passed along.
// The datapath is a 22-stage pipeline that accepts one triangle every cycle unless the
// output stalls; its stages form the exact cross product, the squared length, the
// restoring divide-and-root that yields one quotient bit per stage, and sign and output.
// A stall on the output holds the whole pipeline.
module triangle_face_normal_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tfn_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tfn_pkg::t_out_item o_out_item
);
    import tfn_pkg::*;

    logic       en;
    logic       mag_valid, sq_valid;
    t_mag       mag;
    t_norm      sq_norm;
    logic       st_valid [Q_W+1];
    t_norm      st_norm  [Q_W+1];
    logic       r_out_valid;
    t_out_item  r_out;
    t_out_item  n_out;
    logic signed [COORD_W-1:0] n_comp [LANES];

    assign en = i_out_ready || !r_out_valid;

    tfn_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_valid (mag_valid),
        .o_mag   (mag)
    );

    tfn_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (mag_valid),
        .i_mag   (mag),
        .o_valid (sq_valid),
        .o_norm  (sq_norm)
    );

    assign st_valid[0] = sq_valid;
    assign st_norm[0]  = sq_norm;

    for (genvar g = 0; g < Q_W; g++) begin : g_norm
        tfn_norm_stage #(
            .BIT (Q_W - 1 - g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (st_valid[g]),
            .i_norm  (st_norm[g]),
            .o_valid (st_valid[g+1]),
            .o_norm  (st_norm[g+1])
        );
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (st_norm[Q_W].degen) begin
                n_comp[i] = '0;
            end else if (st_norm[Q_W].neg[i]) begin
                n_comp[i] = -COORD_W'(st_norm[Q_W].q[i]);
            end else begin
                n_comp[i] = COORD_W'(st_norm[Q_W].q[i]);
            end
        end
        n_out.normal_x   = n_comp[0];
        n_out.normal_y   = n_comp[1];
        n_out.normal_z   = n_comp[2];
        n_out.degenerate = st_norm[Q_W].degen;
        n_out.last_out   = st_norm[Q_W].last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= st_valid[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = en;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
endmodule

// ----- hw/rtl/tfn_cross.sv -----
// edges, cross product and component magnitudes over three stages
module tfn_cross (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  tfn_pkg::t_in_item i_item,
    output logic              o_valid,
    output tfn_pkg::t_mag     o_mag
);
    import tfn_pkg::*;

    logic                     r_v1, r_v2, r_v3;
    logic signed [EDGE_W-1:0] r_e [6];
    logic                     r_last1, r_last2;
    logic signed [PROD_W-1:0] r_p [6];
    t_mag                     r_mag;

    logic signed [EDGE_W-1:0]  n_e [6];
    logic signed [CROSS_W-1:0] n_c [LANES];
    t_mag                      n_mag;

    always_comb begin
        n_e[0] = EDGE_W'(i_item.v1_x) - EDGE_W'(i_item.v0_x);
        n_e[1] = EDGE_W'(i_item.v1_y) - EDGE_W'(i_item.v0_y);
        n_e[2] = EDGE_W'(i_item.v1_z) - EDGE_W'(i_item.v0_z);
        n_e[3] = EDGE_W'(i_item.v2_x) - EDGE_W'(i_item.v0_x);
        n_e[4] = EDGE_W'(i_item.v2_y) - EDGE_W'(i_item.v0_y);
        n_e[5] = EDGE_W'(i_item.v2_z) - EDGE_W'(i_item.v0_z);
    end

    always_comb begin
        n_c[0] = CROSS_W'(r_p[0]) - CROSS_W'(r_p[1]);
        n_c[1] = CROSS_W'(r_p[2]) - CROSS_W'(r_p[3]);
        n_c[2] = CROSS_W'(r_p[4]) - CROSS_W'(r_p[5]);
        n_mag.last = r_last2;
        for (int i = 0; i < LANES; i++) begin
            n_mag.neg[i] = n_c[i][CROSS_W-1];
            n_mag.m[i]   = n_c[i][CROSS_W-1] ? MAG_W'(-n_c[i]) : MAG_W'(n_c[i]);
        end
        n_mag.degen = (n_c[0] == '0) && (n_c[1] == '0) && (n_c[2] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e     <= n_e;
            r_last1 <= i_item.last_triangle;
            // e index: 0..2 edge one, 3..5 edge two
            r_p[0]  <= r_e[1] * r_e[5];
            r_p[1]  <= r_e[2] * r_e[4];
            r_p[2]  <= r_e[2] * r_e[3];
            r_p[3]  <= r_e[0] * r_e[5];
            r_p[4]  <= r_e[0] * r_e[4];
            r_p[5]  <= r_e[1] * r_e[3];
            r_last2 <= r_last1;
            r_mag   <= n_mag;
        end
    end

    assign o_valid = r_v3;
    assign o_mag   = r_mag;
endmodule

// ----- hw/rtl/tfn_square.sv -----
// squares of the magnitudes and their sum over three stages
module tfn_square (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  tfn_pkg::t_mag i_mag,
    output logic          o_valid,
    output tfn_pkg::t_norm o_norm
);
    import tfn_pkg::*;

    localparam int unsigned LO_W = 17;
    localparam int unsigned HI_W = MAG_W - LO_W;

    logic                   r_v1, r_v2, r_v3;
    logic [2*HI_W-1:0]      r_hh [LANES];
    logic [HI_W+LO_W-1:0]   r_hl [LANES];
    logic [2*LO_W-1:0]      r_ll [LANES];
    logic [LANES-1:0]       r_neg1, r_neg2;
    logic                   r_degen1, r_degen2, r_last1, r_last2;
    logic [MSQ_W-1:0]       r_msq [LANES];
    t_norm                  r_norm;

    t_norm                  n_norm;

    always_comb begin
        n_norm.s     = SUM_W'(r_msq[0]) + SUM_W'(r_msq[1]) + SUM_W'(r_msq[2]);
        n_norm.neg   = r_neg2;
        n_norm.degen = r_degen2;
        n_norm.last  = r_last2;
        for (int i = 0; i < LANES; i++) begin
            n_norm.r[i] = {r_msq[i], 28'd0};
            n_norm.b[i] = '0;
            n_norm.q[i] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < LANES; i++) begin
                r_hh[i]  <= i_mag.m[i][MAG_W-1:LO_W] * i_mag.m[i][MAG_W-1:LO_W];
                r_hl[i]  <= i_mag.m[i][MAG_W-1:LO_W] * i_mag.m[i][LO_W-1:0];
                r_ll[i]  <= i_mag.m[i][LO_W-1:0] * i_mag.m[i][LO_W-1:0];
                r_msq[i] <= (MSQ_W'(r_hh[i]) << (2*LO_W)) + (MSQ_W'(r_hl[i]) << (LO_W+1))
                          + MSQ_W'(r_ll[i]);
            end
            r_neg1   <= i_mag.neg;
            r_degen1 <= i_mag.degen;
            r_last1  <= i_mag.last;
            r_neg2   <= r_neg1;
            r_degen2 <= r_degen1;
            r_last2  <= r_last1;
            r_norm   <= n_norm;
        end
    end

    assign o_valid = r_v3;
    assign o_norm  = r_norm;
endmodule

// ----- hw/rtl/tfn_norm_stage.sv -----
// one quotient bit of c_i / |c| for all three lanes
module tfn_norm_stage #(
    parameter int unsigned BIT = 14
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  tfn_pkg::t_norm i_norm,
    output logic           o_valid,
    output tfn_pkg::t_norm o_norm
);
    import tfn_pkg::*;

    logic          r_valid;
    t_norm         r_norm;
    t_norm         n_norm;
    logic [CMP_W-1:0] n_d [LANES];

    // cand^2*s - q^2*s = 2^bit * (2*q*s + 2^bit*s), b holds q*s
    always_comb begin
        n_norm = i_norm;
        for (int i = 0; i < LANES; i++) begin
            n_d[i] = (CMP_W'(i_norm.b[i]) << (BIT + 1)) + (CMP_W'(i_norm.s) << (2 * BIT));
            if (CMP_W'(i_norm.r[i]) >= n_d[i]) begin
                n_norm.r[i] = i_norm.r[i] - n_d[i][REM_W-1:0];
                n_norm.b[i] = i_norm.b[i] + (ACC_W'(i_norm.s) << BIT);
                n_norm.q[i] = i_norm.q[i] | (Q_W'(1) << BIT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_norm <= n_norm;
        end
    end

    assign o_valid = r_valid;
    assign o_norm  = r_norm;
endmodule
